// File: sv/pfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and constants of the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int PAGE_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int MAX_PAGES_DEF = 1024;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic busy;
    } ctrl_t;

endpackage

// File: sv/pfla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/pfla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ctrl
// Request sequencer: accept a command, then carry out the update in ST_EXEC.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output pfla_pkg::ctrl_t ctrl
);

    pfla_pkg::state_t state_reg;
    pfla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfla_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pfla_pkg::ST_EXEC;
                end
            end
            pfla_pkg::ST_EXEC:
            begin
                state_next = pfla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            pfla_pkg::ST_IDLE:
            begin
                ctrl.accept = start;
            end
            pfla_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                ctrl.busy = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: sv/page_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator_unit
// LIFO free-list page allocator with a bump counter for never-used pages.
// ----------------------------------------------------------------------------
// Per command, busy is high for one cycle after start is taken, and the
// result shows on the next cycle with done high for exactly one cycle; a
// new command may be started in that same cycle. The split comes from the
// link RAM: the successor of the list head is read when the command is taken
// and used in the following cycle. Results cannot be held off, so capture
// them whenever done is high. Page 0 is never handed out; an allocate falls
// back to the bump counter only when the free list is empty. Refused
// commands raise error and leave the free list and bump counter untouched.
// ----------------------------------------------------------------------------
module page_free_list_allocator_unit #(
    parameter int MAX_PAGES = pfla_pkg::MAX_PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [pfla_pkg::PAGE_W-1:0] page_number,
    output logic                        done,
    output logic [pfla_pkg::PAGE_W-1:0] allocated_page,
    output logic                        error,
    output logic [pfla_pkg::COUNT_W-1:0] free_pages
);

    // Only pages below 2**PAGE_W can ever be freed, so the link RAM stops there.
    localparam int PAGE_SPAN  = 1 << pfla_pkg::PAGE_W;
    localparam int LINK_DEPTH = (MAX_PAGES < PAGE_SPAN) ? MAX_PAGES : PAGE_SPAN;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int EXT_A      = (CNT_W > pfla_pkg::PAGE_W) ? CNT_W : pfla_pkg::PAGE_W;
    localparam int EXT_W      = (EXT_A > pfla_pkg::COUNT_W) ? EXT_A : pfla_pkg::COUNT_W;

    pfla_pkg::ctrl_t ctrl;

    logic                        mode_reg;
    logic [pfla_pkg::PAGE_W-1:0] page_reg;

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  nnp_reg;
    logic [CNT_W-1:0]  nnp_next;

    logic                         done_reg;
    logic [pfla_pkg::PAGE_W-1:0]  given_reg;
    logic [pfla_pkg::PAGE_W-1:0]  given_next;
    logic                         err_reg;
    logic                         err_next;
    logic [pfla_pkg::COUNT_W-1:0] fp_reg;

    logic                link_we;
    logic [ADDR_W-1:0]   link_rdata;
    logic [EXT_W-1:0]    pg_ext;
    logic [EXT_W-1:0]    nnp_ext;
    logic [EXT_W-1:0]    cnt_ext;
    logic [EXT_W-1:0]    head_ext;
    logic [EXT_W-1:0]    cnt_next_ext;

    pfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl)
    );

    // Read the head's successor as the command is taken.
    pfla_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (page_reg[ADDR_W-1:0]),
        .wdata (head_reg),
        .re    (ctrl.accept),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            mode_reg <= mode;
            page_reg <= page_number;
        end
        if (ctrl.exec)
        begin
            given_reg <= given_next;
            err_reg   <= err_next;
            fp_reg    <= cnt_next_ext[pfla_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        pg_ext   = EXT_W'(page_reg);
        nnp_ext  = EXT_W'(nnp_reg);
        cnt_ext  = EXT_W'(count_reg);
        head_ext = EXT_W'(head_reg);

        head_next  = head_reg;
        count_next = count_reg;
        nnp_next   = nnp_reg;
        given_next = '0;
        err_next   = 1'b0;
        link_we    = 1'b0;

        if (mode_reg == pfla_pkg::MODE_ALLOC)
        begin
            if (count_reg != '0)
            begin
                given_next = head_ext[pfla_pkg::PAGE_W-1:0];
                head_next  = link_rdata;
                count_next = count_reg - CNT_W'(1);
            end
            else if (nnp_ext < EXT_W'(MAX_PAGES))
            begin
                given_next = nnp_ext[pfla_pkg::PAGE_W-1:0];
                nnp_next   = nnp_reg + CNT_W'(1);
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        else
        begin
            // Refuse the header page, unissued pages and a list already full.
            if (page_reg == '0 || pg_ext >= nnp_ext || pg_ext >= EXT_W'(MAX_PAGES) ||
                cnt_ext >= nnp_ext - EXT_W'(1))
            begin
                err_next = 1'b1;
            end
            else
            begin
                link_we    = ctrl.exec;
                head_next  = page_reg[ADDR_W-1:0];
                count_next = count_reg + CNT_W'(1);
            end
        end
        cnt_next_ext = EXT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            nnp_reg   <= CNT_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.exec;
            if (ctrl.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                nnp_reg   <= nnp_next;
            end
        end
    end

    assign busy           = ctrl.busy;
    assign done           = done_reg;
    assign allocated_page = given_reg;
    assign error          = err_reg;
    assign free_pages     = fp_reg;

endmodule
